@@ hw/rtl/hsc_pkg.sv @@
// hsc_pkg: widths, item types and per-plane helpers for the homogeneous segment clipper
// depends on nothing; imported by hsc_ratio_pipe and homogeneous_segment_clipper
`default_nettype none

package hsc_pkg;

   localparam int COORD_W      = 32;
   localparam int T_BITS       = 32;
   localparam int T_W          = T_BITS + 1;
   localparam int DIFF_W       = COORD_W + 1;
   localparam int DEN_W        = COORD_W + 2;
   localparam int MAG_W        = COORD_W + 1;
   localparam int HI_W         = MAG_W - T_BITS;
   localparam int PROD_W       = MAG_W + 1;
   localparam int RES_W        = COORD_W + 3;
   localparam int N_COORD      = 4;
   localparam int W_IDX        = 3;
   localparam int N_PLANE      = 6;
   localparam int DIV_STEP     = 2;
   localparam int DIV_STAGES   = T_BITS / DIV_STEP;
   localparam int PL_PER_STAGE = 2;
   localparam int COMB_STAGES  = N_PLANE / PL_PER_STAGE;
   localparam int PIPE_DEPTH   = 3 + DIV_STAGES + COMB_STAGES + 3;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [T_W-1:0] tpar_type;

   localparam tpar_type T_ONE = {1'b1, {T_BITS{1'b0}}};

   localparam logic signed [RES_W-1:0] COORD_MAX_R =
      RES_W'({1'b0, {(COORD_W-1){1'b1}}});
   localparam logic signed [RES_W-1:0] COORD_MIN_R =
      -COORD_MAX_R - RES_W'(1);

   typedef enum logic [1:0] {
      PL_SKIP,
      PL_REJECT,
      PL_ENTER,
      PL_LEAVE
   } plane_kind_type;

   typedef struct packed {
      plane_kind_type kind;
      logic           full;
   } plane_ctl_type;

   typedef struct packed {
      logic     ok;
      tpar_type t0;
      tpar_type t1;
   } clip_state_type;

   typedef struct packed {
      logic                                  trivial;
      coord_type [N_COORD-1:0]               a;
      coord_type [N_COORD-1:0]               b;
      logic      [N_COORD-1:0][MAG_W-1:0]    m;
      logic      [N_COORD-1:0]               neg;
      plane_ctl_type [N_PLANE-1:0]           ctl;
   } seg_side_type;

   typedef struct packed {
      clip_state_type           st;
      tpar_type [N_PLANE-1:0]   r;
      seg_side_type             side;
   } clip_stage_type;

   function automatic clip_state_type apply_plane(clip_state_type s, plane_ctl_type c,
                                                  tpar_type r);
      clip_state_type o;
      o = s;
      if (s.ok) begin
         unique case (c.kind)
            PL_SKIP: begin
               o = s;
            end
            PL_REJECT: begin
               o.ok = 1'b0;
            end
            PL_ENTER: begin
               if (r > s.t1) o.ok = 1'b0;
               else if (r > s.t0) o.t0 = r;
            end
            PL_LEAVE: begin
               if (r < s.t0) o.ok = 1'b0;
               else if (r < s.t1) o.t1 = r;
            end
         endcase
      end
      return o;
   endfunction

   function automatic coord_type sat_coord(logic signed [RES_W-1:0] v);
      coord_type o;
      if (v > COORD_MAX_R) o = COORD_MAX_R[COORD_W-1:0];
      else if (v < COORD_MIN_R) o = COORD_MIN_R[COORD_W-1:0];
      else o = v[COORD_W-1:0];
      return o;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/homogeneous_segment_clipper.sv @@
// homogeneous_segment_clipper: Liang-Barsky clip of a homogeneous segment against -w<=x,y,z<=w
// depends on hsc_pkg and hsc_ratio_pipe
//
// usage
//  req channel: one segment per item, two endpoints of signed Q16.16 x,y,z,w
//  rsp channel: visible flag and the clipped endpoints, or the input endpoints if rejected
//  both channels: item moves on a rising edge with valid high and stall low
//  pipeline: 25 register stages from input capture to the result registers
//  throughput: one item per cycle while rsp is not stalled; every stage advances together
//  the six plane ratios come from six divider pipelines of 16 stages, 2 quotient bits each
//  planes are applied two per stage over three stages, then two stages of
//  multiply and round and one of add and saturate
//  when rsp is stalled with a result waiting, the whole pipeline holds and req_stall rises
//  in the same cycle; nothing is lost or repeated
//  reset clears all valid bits; data registers hold no reset value
`default_nettype none

module homogeneous_segment_clipper (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  hsc_pkg::coord_type    req_start_x,
   input  hsc_pkg::coord_type    req_start_y,
   input  hsc_pkg::coord_type    req_start_z,
   input  hsc_pkg::coord_type    req_start_w,
   input  hsc_pkg::coord_type    req_end_x,
   input  hsc_pkg::coord_type    req_end_y,
   input  hsc_pkg::coord_type    req_end_z,
   input  hsc_pkg::coord_type    req_end_w,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_visible,
   output hsc_pkg::coord_type    rsp_out_start_x,
   output hsc_pkg::coord_type    rsp_out_start_y,
   output hsc_pkg::coord_type    rsp_out_start_z,
   output hsc_pkg::coord_type    rsp_out_start_w,
   output hsc_pkg::coord_type    rsp_out_end_x,
   output hsc_pkg::coord_type    rsp_out_end_y,
   output hsc_pkg::coord_type    rsp_out_end_z,
   output hsc_pkg::coord_type    rsp_out_end_w
);
   import hsc_pkg::*;

   localparam int CMB_BASE = 3 + DIV_STAGES;

   logic                    adv;
   logic [PIPE_DEPTH-1:0]   vld_ff;
   logic [PIPE_DEPTH-1:0]   vld_in;

   coord_type               a_in [N_COORD];
   coord_type               b_in [N_COORD];
   coord_type               a1_ff [N_COORD];
   coord_type               b1_ff [N_COORD];

   logic signed [DIFF_W-1:0] d2_in [N_COORD];
   logic signed [DIFF_W-1:0] q2_in [N_PLANE];
   logic signed [DEN_W-1:0]  p2_in [N_PLANE];
   logic                     triv2_in;
   logic signed [DIFF_W-1:0] d2_ff [N_COORD];
   logic signed [DIFF_W-1:0] q2_ff [N_PLANE];
   logic signed [DEN_W-1:0]  p2_ff [N_PLANE];
   logic                     triv2_ff;
   coord_type                a2_ff [N_COORD];
   coord_type                b2_ff [N_COORD];

   seg_side_type             side3_in;
   seg_side_type             side3_ff;
   logic [DEN_W-1:0]         num3_in [N_PLANE];
   logic [DEN_W-1:0]         den3_in [N_PLANE];
   logic [DEN_W-1:0]         num3_ff [N_PLANE];
   logic [DEN_W-1:0]         den3_ff [N_PLANE];

   seg_side_type             sd_ff [DIV_STAGES];
   logic [T_BITS-1:0]        quo [N_PLANE];

   clip_stage_type           cmb_src [COMB_STAGES];
   clip_stage_type           cmb_in  [COMB_STAGES];
   clip_stage_type           cmb_ff  [COMB_STAGES];

   logic [2*T_BITS-1:0]      mul_in [N_COORD][2];
   logic [2*T_BITS-1:0]      mul_ff [N_COORD][2];
   clip_stage_type           mst1_ff;
   logic [PROD_W-1:0]        prod_in [N_COORD][2];
   logic [PROD_W-1:0]        prod_ff [N_COORD][2];
   clip_stage_type           mst2_ff;

   logic                     vis_in;
   coord_type                os_in [N_COORD];
   coord_type                oe_in [N_COORD];
   logic                     vis_ff;
   coord_type                os_ff [N_COORD];
   coord_type                oe_ff [N_COORD];

   // pipeline control
   assign adv       = !(vld_ff[PIPE_DEPTH-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[PIPE_DEPTH-1];
   assign vld_in    = {vld_ff[PIPE_DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: input capture
   assign a_in[0] = req_start_x;
   assign a_in[1] = req_start_y;
   assign a_in[2] = req_start_z;
   assign a_in[3] = req_start_w;
   assign b_in[0] = req_end_x;
   assign b_in[1] = req_end_y;
   assign b_in[2] = req_end_z;
   assign b_in[3] = req_end_w;

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff <= a_in;
         b1_ff <= b_in;
      end
   end

   // stage 2: deltas and plane distances
   always_comb begin
      for (int i = 0; i < N_COORD; i++) begin
         d2_in[i] = DIFF_W'(b1_ff[i]) - DIFF_W'(a1_ff[i]);
      end
      for (int i = 0; i < N_PLANE / 2; i++) begin
         q2_in[2*i]   = DIFF_W'(a1_ff[W_IDX]) - DIFF_W'(a1_ff[i]);
         q2_in[2*i+1] = DIFF_W'(a1_ff[W_IDX]) + DIFF_W'(a1_ff[i]);
         p2_in[2*i]   = DEN_W'(b1_ff[i]) - DEN_W'(a1_ff[i])
                      - DEN_W'(b1_ff[W_IDX]) + DEN_W'(a1_ff[W_IDX]);
         p2_in[2*i+1] = DEN_W'(a1_ff[W_IDX]) - DEN_W'(b1_ff[W_IDX])
                      + DEN_W'(a1_ff[i]) - DEN_W'(b1_ff[i]);
      end
      triv2_in = a1_ff[W_IDX][COORD_W-1] & b1_ff[W_IDX][COORD_W-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d2_ff    <= d2_in;
         q2_ff    <= q2_in;
         p2_ff    <= p2_in;
         triv2_ff <= triv2_in;
         a2_ff    <= a1_ff;
         b2_ff    <= b1_ff;
      end
   end

   // stage 3: plane classification and divider operands
   always_comb begin
      logic signed [DEN_W-1:0] qx;
      logic signed [DEN_W-1:0] px;
      logic signed [DEN_W-1:0] nqx;
      logic signed [DEN_W-1:0] npx;
      logic signed [DIFF_W-1:0] nd;
      side3_in.trivial = triv2_ff;
      for (int i = 0; i < N_COORD; i++) begin
         side3_in.a[i]   = a2_ff[i];
         side3_in.b[i]   = b2_ff[i];
         nd              = -d2_ff[i];
         side3_in.neg[i] = d2_ff[i][DIFF_W-1];
         side3_in.m[i]   = d2_ff[i][DIFF_W-1] ? MAG_W'(nd) : MAG_W'(d2_ff[i]);
      end
      for (int k = 0; k < N_PLANE; k++) begin
         qx  = DEN_W'(q2_ff[k]);
         px  = p2_ff[k];
         nqx = -qx;
         npx = -px;
         side3_in.ctl[k].kind = PL_SKIP;
         num3_in[k] = qx;
         den3_in[k] = px;
         priority if (px == 0) begin
            side3_in.ctl[k].kind = (qx < 0) ? PL_REJECT : PL_SKIP;
         end else if (px < 0) begin
            priority if (qx > 0) begin
               side3_in.ctl[k].kind = PL_SKIP;
            end else if (nqx > npx) begin
               side3_in.ctl[k].kind = PL_REJECT;
            end else begin
               side3_in.ctl[k].kind = PL_ENTER;
               num3_in[k] = nqx;
               den3_in[k] = npx;
            end
         end else begin
            priority if (qx < 0) begin
               side3_in.ctl[k].kind = PL_REJECT;
            end else if (qx > px) begin
               side3_in.ctl[k].kind = PL_SKIP;
            end else begin
               side3_in.ctl[k].kind = PL_LEAVE;
            end
         end
         side3_in.ctl[k].full = (num3_in[k] == den3_in[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side3_ff <= side3_in;
         num3_ff  <= num3_in;
         den3_ff  <= den3_in;
      end
   end

   // plane ratio dividers with matching sideband delay
   for (genvar k = 0; k < N_PLANE; k++) begin : g_div
      hsc_ratio_pipe u_ratio (
         .clock (clock),
         .adv   (adv),
         .num   (num3_ff[k]),
         .den   (den3_ff[k]),
         .quo   (quo[k])
      );
   end

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_side
      if (s == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (adv) sd_ff[s] <= side3_ff;
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (adv) sd_ff[s] <= sd_ff[s-1];
         end
      end
   end

   // plane combine, two planes per stage
   always_comb begin
      cmb_src[0].st.ok   = !sd_ff[DIV_STAGES-1].trivial;
      cmb_src[0].st.t0   = '0;
      cmb_src[0].st.t1   = T_ONE;
      cmb_src[0].side    = sd_ff[DIV_STAGES-1];
      for (int k = 0; k < N_PLANE; k++) begin
         cmb_src[0].r[k] = sd_ff[DIV_STAGES-1].ctl[k].full ? T_ONE : {1'b0, quo[k]};
      end
   end

   for (genvar j = 0; j < COMB_STAGES; j++) begin : g_cmb
      if (j > 0) begin : g_src
         assign cmb_src[j] = cmb_ff[j-1];
      end

      always_comb begin
         clip_state_type st;
         st = cmb_src[j].st;
         for (int k = 0; k < PL_PER_STAGE; k++) begin
            st = apply_plane(st, cmb_src[j].side.ctl[j*PL_PER_STAGE+k],
                             cmb_src[j].r[j*PL_PER_STAGE+k]);
         end
         cmb_in[j]    = cmb_src[j];
         cmb_in[j].st = st;
      end

      always_ff @(posedge clock) begin
         if (adv) cmb_ff[j] <= cmb_in[j];
      end
   end

   // multiply low magnitude by t0 and t1
   always_comb begin
      logic [T_BITS-1:0] lo;
      for (int i = 0; i < N_COORD; i++) begin
         lo = cmb_ff[COMB_STAGES-1].side.m[i][T_BITS-1:0];
         mul_in[i][0] = lo * cmb_ff[COMB_STAGES-1].st.t0[T_BITS-1:0];
         mul_in[i][1] = lo * cmb_ff[COMB_STAGES-1].st.t1[T_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mul_ff  <= mul_in;
         mst1_ff <= cmb_ff[COMB_STAGES-1];
      end
   end

   // round and add the high part
   always_comb begin
      logic [T_BITS-1:0]   lo;
      logic [HI_W-1:0]     hi;
      logic [2*T_BITS:0]   rnd;
      logic [PROD_W-1:0]   hi_t;
      tpar_type            tt;
      for (int i = 0; i < N_COORD; i++) begin
         lo = mst1_ff.side.m[i][T_BITS-1:0];
         hi = mst1_ff.side.m[i][MAG_W-1:T_BITS];
         for (int j = 0; j < 2; j++) begin
            tt   = (j == 0) ? mst1_ff.st.t0 : mst1_ff.st.t1;
            rnd  = (2*T_BITS+1)'(mul_ff[i][j]) + ((2*T_BITS+1)'(1) << (T_BITS-1));
            hi_t = '0;
            for (int h = 0; h < HI_W; h++) begin
               if (hi[h]) hi_t = hi_t + (PROD_W'(tt) << h);
            end
            prod_in[i][j] = hi_t + (tt[T_BITS] ? PROD_W'(lo)
                                               : PROD_W'(rnd[2*T_BITS:T_BITS]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         mst2_ff <= mst1_ff;
      end
   end

   // endpoint add, saturate and select
   always_comb begin
      logic signed [RES_W-1:0] rs;
      logic signed [RES_W-1:0] re;
      vis_in = mst2_ff.st.ok;
      for (int i = 0; i < N_COORD; i++) begin
         rs = mst2_ff.side.neg[i] ? RES_W'(mst2_ff.side.a[i]) - RES_W'(prod_ff[i][0])
                                  : RES_W'(mst2_ff.side.a[i]) + RES_W'(prod_ff[i][0]);
         re = mst2_ff.side.neg[i] ? RES_W'(mst2_ff.side.a[i]) - RES_W'(prod_ff[i][1])
                                  : RES_W'(mst2_ff.side.a[i]) + RES_W'(prod_ff[i][1]);
         os_in[i] = mst2_ff.st.ok ? sat_coord(rs) : mst2_ff.side.a[i];
         oe_in[i] = mst2_ff.st.ok ? sat_coord(re) : mst2_ff.side.b[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vis_ff <= vis_in;
         os_ff  <= os_in;
         oe_ff  <= oe_in;
      end
   end

   assign rsp_visible     = vis_ff;
   assign rsp_out_start_x = os_ff[0];
   assign rsp_out_start_y = os_ff[1];
   assign rsp_out_start_z = os_ff[2];
   assign rsp_out_start_w = os_ff[3];
   assign rsp_out_end_x   = oe_ff[0];
   assign rsp_out_end_y   = oe_ff[1];
   assign rsp_out_end_z   = oe_ff[2];
   assign rsp_out_end_w   = oe_ff[3];

   // checks
   a_stall_tracks_out: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output hold");

   a_valid_shift: assert property (@(posedge clock) disable iff (reset)
      !req_stall |=> vld_ff[PIPE_DEPTH-1] == $past(vld_ff[PIPE_DEPTH-2]))
      else $error("valid bit lost or repeated in pipeline");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> vld_ff == $past(vld_ff))
      else $error("pipeline moved while held");

   a_t_order: assert property (@(posedge clock) disable iff (reset)
      vld_ff[CMB_BASE+COMB_STAGES-1] && cmb_ff[COMB_STAGES-1].st.ok
         |-> cmb_ff[COMB_STAGES-1].st.t0 <= cmb_ff[COMB_STAGES-1].st.t1)
      else $error("visible segment with t0 above t1");

endmodule

`default_nettype wire

@@ hw/rtl/hsc_ratio_pipe.sv @@
// hsc_ratio_pipe: pipelined restoring divider, floor(num * 2^T_BITS / den) for num < den
// depends on hsc_pkg; DIV_STEP quotient bits per register stage
`default_nettype none

module hsc_ratio_pipe (
   input  logic                         clock,
   input  logic                         adv,
   input  logic [hsc_pkg::DEN_W-1:0]    num,
   input  logic [hsc_pkg::DEN_W-1:0]    den,
   output logic [hsc_pkg::T_BITS-1:0]   quo
);
   import hsc_pkg::*;

   logic [DEN_W-1:0]  rem_src [DIV_STAGES];
   logic [DEN_W-1:0]  den_src [DIV_STAGES];
   logic [T_BITS-1:0] quo_src [DIV_STAGES];
   logic [DEN_W-1:0]  rem_in  [DIV_STAGES];
   logic [T_BITS-1:0] quo_in  [DIV_STAGES];
   logic [DEN_W-1:0]  rem_ff  [DIV_STAGES];
   logic [DEN_W-1:0]  den_ff  [DIV_STAGES];
   logic [T_BITS-1:0] quo_ff  [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign rem_src[s] = num;
         assign den_src[s] = den;
         assign quo_src[s] = '0;
      end else begin : g_next
         assign rem_src[s] = rem_ff[s-1];
         assign den_src[s] = den_ff[s-1];
         assign quo_src[s] = quo_ff[s-1];
      end

      always_comb begin
         logic [DEN_W-1:0]  r;
         logic [DEN_W:0]    r2;
         logic [T_BITS-1:0] qq;
         r  = rem_src[s];
         qq = quo_src[s];
         r2 = '0;
         for (int k = 0; k < DIV_STEP; k++) begin
            r2 = {r, 1'b0};
            if (r2 >= {1'b0, den_src[s]}) begin
               r2 = r2 - {1'b0, den_src[s]};
               qq = {qq[T_BITS-2:0], 1'b1};
            end else begin
               qq = {qq[T_BITS-2:0], 1'b0};
            end
            r = r2[DEN_W-1:0];
         end
         rem_in[s] = r;
         quo_in[s] = qq;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s] <= rem_in[s];
            den_ff[s] <= den_src[s];
            quo_ff[s] <= quo_in[s];
         end
      end
   end

   assign quo = quo_ff[DIV_STAGES-1];

endmodule

`default_nettype wire
